// ----- design/mav_pkg.sv -----
// Shared types for the moving average window block.
// Holds the controller state encoding and the command and status bundles.
// No dependencies.
package mav_pkg;

  localparam int WIN_LEN_W = 7;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SUM,
    ST_DIV,
    ST_DONE
  } mav_state_t;

  typedef struct packed {
    logic take;
    logic sum;
    logic div_load;
    logic div_step;
    logic out_load;
  } mav_cmd_t;

  typedef struct packed {
    logic sum_done;
    logic div_done;
    logic out_free;
  } mav_status_t;

endpackage

// ----- design/mav_ram.sv -----
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
module mav_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- design/mav_ctrl.sv -----
// Controller for the moving average window: sequences store, sum, divide and
// result hand-off. Depends on mav_pkg.
module mav_ctrl
  import mav_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  mav_status_t status,
  output mav_cmd_t    cmd
);

  mav_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.take   = 1'b1;
          state_next = ST_SUM;
        end
      end
      ST_SUM: begin
        cmd.sum = 1'b1;
        if (status.sum_done) begin
          cmd.div_load = 1'b1;
          state_next   = ST_DIV;
        end
      end
      ST_DIV: begin
        if (status.div_done) begin
          state_next = ST_DONE;
        end else begin
          cmd.div_step = 1'b1;
        end
      end
      ST_DONE: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

// ----- design/mav_datapath.sv -----
// Datapath for the moving average window: sample ring, window sum,
// bit-serial divider, result register and window length register.
// Depends on mav_pkg and mav_ram.
module mav_datapath
  import mav_pkg::*;
#(
  parameter int MAX_WINDOW  = 64,
  parameter int SAMPLE_BITS = 24
) (
  input  logic                   clk,
  input  logic                   rst,
  input  mav_cmd_t               cmd,
  output mav_status_t            status,
  input  logic                   cfg_we,
  input  logic [WIN_LEN_W-1:0]   cfg_wdata,
  input  logic [SAMPLE_BITS-1:0] in_sample,
  input  logic                   in_restart,
  input  logic                   out_ready,
  output logic                   out_valid,
  output logic [SAMPLE_BITS-1:0] out_mean
);

  localparam int ADDR_W = $clog2(MAX_WINDOW);
  localparam int LEN_W  = $clog2(MAX_WINDOW + 1);
  localparam int SUM_W  = SAMPLE_BITS + $clog2(MAX_WINDOW);
  localparam int CNT_W  = $clog2(SUM_W + 1);
  localparam int WIN_W  = (LEN_W > WIN_LEN_W) ? LEN_W : WIN_LEN_W;

  logic [WIN_LEN_W-1:0]   window_len;
  logic [ADDR_W-1:0]      slot;
  logic [LEN_W-1:0]       filled;
  logic [LEN_W-1:0]       len;
  logic [LEN_W-1:0]       issue_cnt;
  logic [ADDR_W-1:0]      rd_ptr;
  logic                   rd_valid;
  logic [SUM_W-1:0]       acc;
  logic [LEN_W-1:0]       rem;
  logic [SUM_W-1:0]       quo;
  logic                   neg;
  logic [CNT_W-1:0]       bit_cnt;

  logic [ADDR_W-1:0]      slot_eff;
  logic [ADDR_W-1:0]      slot_inc;
  logic [ADDR_W-1:0]      rd_ptr_dec;
  logic [LEN_W-1:0]       filled_eff;
  logic [LEN_W-1:0]       filled_inc;
  logic [WIN_W-1:0]       win_ext;
  logic [WIN_W-1:0]       win_clip;
  logic [LEN_W-1:0]       win;
  logic [LEN_W-1:0]       len_new;
  logic                   ram_re;
  logic [SAMPLE_BITS-1:0] ram_rdata;
  logic [SUM_W-1:0]       rdata_ext;
  logic [SUM_W-1:0]       acc_mag;
  logic [LEN_W:0]         rem_shift;
  logic [LEN_W:0]         rem_sub;
  logic                   div_ge;
  logic [LEN_W-1:0]       rem_div;
  logic [SAMPLE_BITS-1:0] quo_trunc;
  logic [SAMPLE_BITS-1:0] mean_val;

  always_comb begin
    slot_eff   = in_restart ? '0 : slot;
    filled_eff = in_restart ? '0 : filled;
    filled_inc = (filled_eff == LEN_W'(MAX_WINDOW)) ? filled_eff : filled_eff + 1'b1;
    win_ext    = WIN_W'(window_len);
    win_clip   = (win_ext > WIN_W'(MAX_WINDOW)) ? WIN_W'(MAX_WINDOW) : win_ext;
    win        = win_clip[LEN_W-1:0];
    len_new    = (filled_inc < win) ? filled_inc : win;
    slot_inc   = (slot_eff == ADDR_W'(MAX_WINDOW - 1)) ? '0 : slot_eff + 1'b1;
    rd_ptr_dec = (rd_ptr == '0) ? ADDR_W'(MAX_WINDOW - 1) : rd_ptr - 1'b1;
    ram_re     = cmd.sum && (issue_cnt != '0);
    rdata_ext  = {{(SUM_W - SAMPLE_BITS){ram_rdata[SAMPLE_BITS-1]}}, ram_rdata};
    acc_mag    = acc[SUM_W-1] ? (~acc + 1'b1) : acc;
    rem_shift  = {rem, quo[SUM_W-1]};
    div_ge     = (rem_shift >= {1'b0, len});
    rem_sub    = rem_shift - {1'b0, len};
    rem_div    = div_ge ? rem_sub[LEN_W-1:0] : rem_shift[LEN_W-1:0];
    quo_trunc  = quo[SAMPLE_BITS-1:0];
    mean_val   = (len == '0) ? '0 : (neg ? (~quo_trunc + 1'b1) : quo_trunc);
  end

  mav_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (MAX_WINDOW)
  ) u_store (
    .clk   (clk),
    .we    (cmd.take),
    .waddr (slot_eff),
    .wdata (in_sample),
    .re    (ram_re),
    .raddr (rd_ptr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      window_len <= WIN_LEN_W'(1);
      slot       <= '0;
      filled     <= '0;
      issue_cnt  <= '0;
      rd_valid   <= 1'b0;
      bit_cnt    <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_we) begin
        window_len <= cfg_wdata;
      end
      rd_valid <= ram_re;
      if (cmd.take) begin
        slot      <= slot_inc;
        filled    <= filled_inc;
        issue_cnt <= len_new;
      end else if (ram_re) begin
        issue_cnt <= issue_cnt - 1'b1;
      end
      if (cmd.div_load) begin
        bit_cnt <= CNT_W'(SUM_W);
      end else if (cmd.div_step) begin
        bit_cnt <= bit_cnt - 1'b1;
      end
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      len    <= len_new;
      rd_ptr <= slot_eff;
      acc    <= '0;
    end else begin
      if (ram_re) begin
        rd_ptr <= rd_ptr_dec;
      end
      if (rd_valid) begin
        acc <= acc + rdata_ext;
      end
    end
    if (cmd.div_load) begin
      rem <= '0;
      quo <= acc_mag;
      neg <= acc[SUM_W-1];
    end else if (cmd.div_step) begin
      rem <= rem_div;
      quo <= {quo[SUM_W-2:0], div_ge};
    end
    if (cmd.out_load) begin
      out_mean <= mean_val;
    end
  end

  assign status.sum_done = (issue_cnt == '0) && !rd_valid;
  assign status.div_done = (bit_cnt == '0);
  assign status.out_free = !out_valid || out_ready;

  a_filled_bound: assert property (@(posedge clk) disable iff (rst)
    filled <= LEN_W'(MAX_WINDOW))
    else $error("fill count beyond window store");

  a_issue_bound: assert property (@(posedge clk) disable iff (rst)
    $past(cmd.take) |-> (issue_cnt <= filled))
    else $error("sum length exceeds samples held");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!out_valid || out_ready))
    else $error("result register loaded while a result is pending");

  a_div_idle_sum: assert property (@(posedge clk) disable iff (rst)
    cmd.div_step |-> (!rd_valid && issue_cnt == '0))
    else $error("divider stepping while summation in flight");

endmodule

// ----- design/moving_average_window.sv -----
// Top level of the moving average window: stream ports, configuration port,
// controller and datapath. Depends on mav_pkg, mav_ctrl and mav_datapath.
//
// Each input transfer carries one signed Q15.8 sample and a restart flag in
// tuser; each produces one output transfer with the mean of the last
// L = min(samples since restart, window_len, MAX_WINDOW) samples, truncated
// toward zero (zero when window_len is zero). Items are handled one at a time:
// the result is presented once the summing pass and the divider have finished
// and the output is free, and the next sample is accepted from the same cycle
// on. The transfer time is set by the summing pass that reads one stored
// sample per cycle from the single read port of the sample RAM and by the
// divider that resolves one quotient bit per cycle. A new sample is accepted
// while the previous result still waits on the output. Write window_len only
// while no transfer is in progress.
module moving_average_window
  import mav_pkg::*;
#(
  parameter int MAX_WINDOW  = 64,
  parameter int SAMPLE_BITS = 24
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    cfg_we,
  input  logic [WIN_LEN_W-1:0]                    cfg_wdata,      // window_len
  input  logic                                    s_axis_tvalid,
  output logic                                    s_axis_tready,
  input  logic [((SAMPLE_BITS + 7) / 8) * 8 - 1:0] s_axis_tdata,  // sample
  input  logic                                    s_axis_tuser,   // restart
  output logic                                    m_axis_tvalid,
  input  logic                                    m_axis_tready,
  output logic [((SAMPLE_BITS + 7) / 8) * 8 - 1:0] m_axis_tdata   // mean
);

  localparam int DATA_W = ((SAMPLE_BITS + 7) / 8) * 8;

  mav_cmd_t               cmd;
  mav_status_t            status;
  logic [SAMPLE_BITS-1:0] mean;

  mav_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .status   (status),
    .cmd      (cmd)
  );

  mav_datapath #(
    .MAX_WINDOW  (MAX_WINDOW),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .status     (status),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_sample  (s_axis_tdata[SAMPLE_BITS-1:0]),
    .in_restart (s_axis_tuser),
    .out_ready  (m_axis_tready),
    .out_valid  (m_axis_tvalid),
    .out_mean   (mean)
  );

  assign m_axis_tdata = DATA_W'(mean);

endmodule

// ----- verif/moving_average_window_tb.sv -----
// Self-checking testbench for moving_average_window: stream stimulus, window
// register writes and a scoreboard that predicts each windowed mean.
// Depends on mav_pkg and moving_average_window.
module moving_average_window_tb
  import mav_pkg::*;
();

  localparam int MAX_WINDOW     = 64;
  localparam int SAMPLE_BITS    = 24;
  localparam int PHASES         = 12;
  localparam int PHASE_ITEMS    = 52;
  localparam int RX_HOLD_CYCLES = 400;
  localparam int SETTLE_CYCLES  = 120;
  localparam int WATCHDOG_LIMIT = 4000;

  localparam logic [SAMPLE_BITS-1:0] SAMPLE_MAX = 24'h7FFFFF;
  localparam logic [SAMPLE_BITS-1:0] SAMPLE_MIN = 24'h800000;

  typedef enum int { IDLE_NONE, IDLE_TX, IDLE_RX, IDLE_BOTH } idle_mode_t;

  class mav_scoreboard;
    logic signed [SAMPLE_BITS-1:0] ring [MAX_WINDOW];
    logic [SAMPLE_BITS-1:0] means_q [$];
    int unsigned wr_slot;
    int unsigned filled;
    int unsigned window;
    int unsigned samples_seen;
    int unsigned means_checked;
    int unsigned restarts;
    int unsigned zero_means;
    int unsigned errors;

    function new();
      wr_slot = 0;
      filled  = 0;
      window  = 1;
    endfunction

    function void set_window(logic [WIN_LEN_W-1:0] len);
      window = len;
    endfunction

    function int unsigned pending();
      return means_q.size();
    endfunction

    function void note_sample(logic [SAMPLE_BITS-1:0] raw, logic restart);
      longint total;
      longint mean;
      int unsigned eff_win;
      int unsigned span;
      total = 0;
      if (restart) begin
        wr_slot = 0;
        filled  = 0;
        restarts++;
      end
      ring[wr_slot] = raw;
      if (filled < MAX_WINDOW) filled++;
      eff_win = (window > MAX_WINDOW) ? MAX_WINDOW : window;
      span = (filled < eff_win) ? filled : eff_win;
      for (int k = 0; k < span; k++) begin
        total += ring[(wr_slot + MAX_WINDOW - k) % MAX_WINDOW];
      end
      wr_slot = (wr_slot + 1) % MAX_WINDOW;
      mean = (span > 0) ? total / longint'(span) : 0;
      if (span == 0) zero_means++;
      means_q.push_back(mean[SAMPLE_BITS-1:0]);
      samples_seen++;
    endfunction

    function void check_mean(logic [SAMPLE_BITS-1:0] got);
      logic [SAMPLE_BITS-1:0] want;
      if (means_q.size() == 0) begin
        errors++;
        $error("mean: unexpected transfer, expected none, actual %0d", $signed(got));
        return;
      end
      want = means_q.pop_front();
      means_checked++;
      if (got !== want) begin
        errors++;
        $error("mean mismatch: expected %0d, actual %0d", $signed(want), $signed(got));
      end
    endfunction
  endclass

  logic                   clk;
  logic                   rst = 1'b1;
  logic                   cfg_we = 1'b0;
  logic [WIN_LEN_W-1:0]   cfg_wdata = '0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [SAMPLE_BITS-1:0] s_axis_tdata = '0;   // sample
  logic                   s_axis_tuser = 1'b0; // restart
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [SAMPLE_BITS-1:0] m_axis_tdata;        // mean

  mav_scoreboard sb = new();
  int unsigned   tx_idle_pct = 0;
  int unsigned   rx_stall_pct = 0;
  bit            rx_hold_req = 1'b0;
  int unsigned   quiet_cycles = 0;

  moving_average_window dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    forever begin
      @(posedge clk);
      if (rx_hold_req) begin
        m_axis_tready <= 1'b0;
        repeat (RX_HOLD_CYCLES) @(posedge clk);
        rx_hold_req = 1'b0;
      end
      m_axis_tready <= (rx_stall_pct == 0) ? 1'b1 : ($urandom_range(99) >= rx_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (m_axis_tvalid && m_axis_tready) sb.check_mean(m_axis_tdata);
      if (s_axis_tvalid && s_axis_tready) sb.note_sample(s_axis_tdata, s_axis_tuser);
      if ((m_axis_tvalid && m_axis_tready) || (s_axis_tvalid && s_axis_tready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
        $display("tb: failure");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  task automatic set_idle(idle_mode_t mode);
    tx_idle_pct  = (mode == IDLE_TX) ? 53 : (mode == IDLE_BOTH) ? 9 : 0;
    rx_stall_pct = (mode == IDLE_RX) ? 53 : (mode == IDLE_BOTH) ? 9 : 0;
  endtask

  // leaves tvalid high; the caller either sends again or drains
  task automatic send_sample(logic [SAMPLE_BITS-1:0] raw, logic restart);
    int unsigned gap;
    gap = 0;
    if (tx_idle_pct != 0) begin
      while ($urandom_range(99) < tx_idle_pct) gap++;
    end
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= raw;
    s_axis_tuser  <= restart;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
  endtask

  task automatic drain_means();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_window(logic [WIN_LEN_W-1:0] len);
    drain_means();
    cfg_we    <= 1'b1;
    cfg_wdata <= len;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_window(len);
  endtask

  function automatic logic [SAMPLE_BITS-1:0] pick_sample();
    case ($urandom_range(3))
      0:       return SAMPLE_BITS'($urandom);
      1:       return SAMPLE_BITS'(int'($urandom_range(511)) - 256);
      2:       return $urandom_range(1) ? SAMPLE_MAX : SAMPLE_MIN;
      default: return SAMPLE_BITS'($urandom);
    endcase
  endfunction

  initial begin
    logic [WIN_LEN_W-1:0] phase_win [PHASES];
    phase_win = '{7'd1, 7'd64, 7'd0, 7'd127, 7'd2, 7'd65, 7'd7, 7'd33,
                  7'd16, 7'd100, 7'd3, 7'd64};

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_sample(SAMPLE_MAX, 1'b0);
    send_sample(SAMPLE_MIN, 1'b0);

    write_window(7'd64);
    send_sample(SAMPLE_MIN, 1'b1);
    send_sample(SAMPLE_MIN, 1'b0);
    send_sample(SAMPLE_MIN, 1'b0);
    send_sample(SAMPLE_MAX, 1'b0);
    send_sample(24'hFFFFFF, 1'b0);
    send_sample(24'h000001, 1'b0);
    send_sample(24'h000000, 1'b0);

    write_window(7'd0);
    send_sample(24'd12345, 1'b0);
    send_sample(24'hFFFFFF, 1'b0);

    write_window(7'd127);
    send_sample(SAMPLE_MAX, 1'b0);

    write_window(7'd3);
    send_sample(-24'sd7, 1'b0);
    send_sample(24'd2, 1'b0);
    send_sample(24'd1, 1'b0);
    send_sample(24'd5, 1'b1);
    send_sample(-24'sd2, 1'b0);

    write_window(7'd2);
    send_sample(-24'sd3, 1'b1);
    send_sample(24'd0, 1'b0);

    for (int p = 0; p < PHASES; p++) begin
      write_window((p < PHASES - 1) ? phase_win[p] : WIN_LEN_W'($urandom_range(127)));
      set_idle(idle_mode_t'(p % 4));
      if (p == 4) rx_hold_req = 1'b1;
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        send_sample(pick_sample(),
                    (i == 0) ? 1'($urandom_range(1)) : ($urandom_range(99) < 2));
      end
    end

    drain_means();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("summary: %0d samples, %0d means checked, %0d restarts, %0d zero-window means",
             sb.samples_seen, sb.means_checked, sb.restarts, sb.zero_means);
    $display("summary: windows 0 to 127 incl. beyond store depth, four idling modes, long hold-off");
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
